// File: hdl/qoi_image_encoder_top_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef QOI_IMAGE_ENCODER_TOP_DEFINES_SVH
`define QOI_IMAGE_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QOI_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qoi encoder check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QOI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qoi encoder check failed");

`endif

// File: hdl/qoienc_pkg.sv
// Shared constants and types of the QOI stream encoder.
package qoienc_pkg;

  localparam int unsigned PixelW     = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned IndexDepth = 64;
  localparam int unsigned IndexAw    = 6;
  localparam int unsigned RunW       = 6;
  localparam int unsigned MaxRun     = 62;
  localparam int unsigned HdrLen     = 14;
  localparam int unsigned EndLen     = 8;
  localparam int unsigned OpMaxLen   = 5;
  localparam int unsigned OpLenW     = 3;
  localparam int unsigned SeqIdxW    = 4;
  localparam int unsigned ChanW      = 3;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [PixelW-1:0] PrevReset = 32'hff00_0000;

  localparam logic [ByteW-1:0] Magic0 = 8'h71;
  localparam logic [ByteW-1:0] Magic1 = 8'h6f;
  localparam logic [ByteW-1:0] Magic2 = 8'h69;
  localparam logic [ByteW-1:0] Magic3 = 8'h66;

  localparam logic [ByteW-1:0] OpRun  = 8'hc0;
  localparam logic [ByteW-1:0] OpDiff = 8'h40;
  localparam logic [ByteW-1:0] OpLuma = 8'h80;
  localparam logic [ByteW-1:0] OpRgb  = 8'hfe;
  localparam logic [ByteW-1:0] OpRgba = 8'hff;

  localparam logic [ByteW-1:0] EndFinal = 8'h01;

  localparam logic [IndexAw-1:0] HashR = 6'd3;
  localparam logic [IndexAw-1:0] HashG = 6'd5;
  localparam logic [IndexAw-1:0] HashB = 6'd7;
  localparam logic [IndexAw-1:0] HashA = 6'd11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CHANNELS = 2'd2
  } cfg_reg_e;

  // Byte sequencer phases, one bit each; the lowest pending bit is active.
  typedef enum logic [3:0] {
    PH_HDR = 4'b0001,
    PH_RUN = 4'b0010,
    PH_OP  = 4'b0100,
    PH_END = 4'b1000
  } phase_e;

  // Only the low six bits of each channel matter modulo 64.
  function automatic logic [IndexAw-1:0] hash_fn(input logic [PixelW-1:0] px);
    hash_fn = px[5:0] * HashR + px[13:8] * HashG + px[21:16] * HashB + px[29:24] * HashA;
  endfunction

endpackage

// File: hdl/qoienc_ram.sv
// Generic simple dual-port RAM with registered read data.
module qoienc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read returns the old word on a same-address write
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/qoi_image_encoder_top.sv
// QOI image encoder: one RGBA pixel per input item, one stream byte per output item.
// Input: s_axis tdata = pixel (red 7:0, green 15:8, blue 23:16, alpha 31:24),
//   tlast = last pixel of the frame.
// Output: m_axis tdata = encoded byte, tlast = final byte caused by that pixel,
//   tuser = final end-marker byte of the frame.
// Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 width, 1 height,
//   2 channels); write only while the encoder is idle.
// The first pixel of a frame also emits the 14-byte header; a last pixel adds the
//   8-byte end marker and returns the encoder to its start-of-frame state.
// Path: a pixel's bytes pass the entry-stage registers, the byte sequencer and the output register.
// Throughput: one output byte per cycle while the receiver takes it; a pixel causes
//   1 to 6 bytes with a pending run flushed, plus 14 and 8 at frame edges, and
//   none when it only extends a run. The byte-wide output register sets the
//   rate; the color index RAM is read as the pixel enters and written back as the
//   pixel leaves the decision stage.
// Reset clears the index valid bits, the run, the previous pixel and the header
//   flag; an entry without its valid bit reads as zero, so no clearing pass.
// A stalled receiver holds the output byte; the sequencer and then the input
//   side back up in turn, and no byte is lost.
`include "qoi_image_encoder_top_defines.svh"

module qoi_image_encoder_top
  import qoienc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [PixelW-1:0]   s_axis_tdata_i,   // pixel
  input  logic                s_axis_tlast_i,   // last_pixel
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [ByteW-1:0]    m_axis_tdata_o,   // out_byte
  output logic                m_axis_tlast_o,   // last_of_item
  output logic [0:0]          m_axis_tuser_o,   // frame_end
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [PixelW-1:0]   cfg_wdata_i
);

  // configuration
  logic [PixelW-1:0] width_q, height_q;
  logic [ChanW-1:0]  chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 32'd1;
      height_q <= 32'd1;
      chan_q   <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH:    width_q  <= cfg_wdata_i;
        REG_HEIGHT:   height_q <= cfg_wdata_i;
        REG_CHANNELS: chan_q   <= cfg_wdata_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // entry stage: hash and index read
  logic               s_acc;
  logic [IndexAw-1:0] in_hash;
  logic               s1_v_q;
  logic [PixelW-1:0]  s1_px_q;
  logic               s1_last_q;
  logic [IndexAw-1:0] s1_hash_q;
  logic               fwd_hit_q;
  logic [PixelW-1:0]  fwd_data_q;
  logic               s1_fire;

  logic [PixelW-1:0]     ram_rdata;
  logic                  ram_we;
  logic [IndexDepth-1:0] vld_q;
  logic [PixelW-1:0]     prev_q;
  logic [RunW-1:0]       run_q;
  logic                  hdr_sent_q;

  assign in_hash         = hash_fn(s_axis_tdata_i);
  assign s_axis_tready_o = !s1_v_q || s1_fire;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  qoienc_ram #(
    .Width (PixelW),
    .Depth (IndexDepth)
  ) u_index (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_hash_q),
    .wdata_i (s1_px_q),
    .re_i    (s_acc),
    .raddr_i (in_hash),
    .rdata_o (ram_rdata)
  );

  // decision stage
  logic              same, entry_hit, need_op, wr;
  logic [RunW:0]     run_inc;
  logic              flush_same, run_flush, silent;
  logic [ByteW-1:0]  run_byte;
  logic [PixelW-1:0] entry;
  logic signed [ByteW-1:0] dr, dg, db, drg, dbg;
  logic              alpha_eq, small_diff, luma_ok;
  logic [ByteW-1:0]  op_d [OpMaxLen];
  logic [OpLenW-1:0] op_len_d;

  assign entry     = fwd_hit_q ? fwd_data_q : ram_rdata;
  // an entry not yet written this frame holds zero
  assign entry_hit = ((vld_q[s1_hash_q] ? entry : '0) == s1_px_q);
  assign same      = (s1_px_q == prev_q);
  assign need_op   = !same;
  assign wr        = need_op && !entry_hit;

  assign run_inc    = {1'b0, run_q} + 7'd1;
  assign flush_same = (run_inc >= 7'(MaxRun)) || s1_last_q;
  assign run_flush  = same ? flush_same : (run_q != '0);
  assign run_byte   = OpRun | {2'b00, (same ? run_q : run_q - 6'd1)};

  assign dr  = $signed(s1_px_q[7:0]   - prev_q[7:0]);
  assign dg  = $signed(s1_px_q[15:8]  - prev_q[15:8]);
  assign db  = $signed(s1_px_q[23:16] - prev_q[23:16]);
  assign drg = dr - dg;
  assign dbg = db - dg;
  assign alpha_eq   = (s1_px_q[31:24] == prev_q[31:24]);
  assign small_diff = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1)
                   && (db >= -8'sd2) && (db <= 8'sd1);
  assign luma_ok    = (drg >= -8'sd8) && (drg <= 8'sd7) && (dg >= -8'sd32) && (dg <= 8'sd31)
                   && (dbg >= -8'sd8) && (dbg <= 8'sd7);

  always_comb begin
    for (int i = 0; i < OpMaxLen; i++) begin
      op_d[i] = '0;
    end
    op_len_d = '0;
    if (need_op) begin
      if (entry_hit) begin
        op_d[0]  = {2'b00, s1_hash_q};
        op_len_d = 3'd1;
      end else if (!alpha_eq) begin
        op_d[0]  = OpRgba;
        op_d[1]  = s1_px_q[7:0];
        op_d[2]  = s1_px_q[15:8];
        op_d[3]  = s1_px_q[23:16];
        op_d[4]  = s1_px_q[31:24];
        op_len_d = 3'd5;
      end else if (small_diff) begin
        op_d[0]  = OpDiff | {2'b00, dr[1:0] + 2'd2, dg[1:0] + 2'd2, db[1:0] + 2'd2};
        op_len_d = 3'd1;
      end else if (luma_ok) begin
        op_d[0]  = OpLuma | {2'b00, dg[5:0] + 6'd32};
        op_d[1]  = {drg[3:0] + 4'd8, dbg[3:0] + 4'd8};
        op_len_d = 3'd2;
      end else begin
        op_d[0]  = OpRgb;
        op_d[1]  = s1_px_q[7:0];
        op_d[2]  = s1_px_q[15:8];
        op_d[3]  = s1_px_q[23:16];
        op_len_d = 3'd4;
      end
    end
  end

  // pixel that only extends a run
  assign silent = hdr_sent_q && !run_flush && (op_len_d == '0) && !s1_last_q;

  // byte sequencer
  logic [3:0]         pend_q, pend_d, cur, rest;
  phase_e             phase;
  logic [SeqIdxW-1:0] idx_q, idx_d;
  logic [ByteW-1:0]   run_byte_q;
  logic [ByteW-1:0]   op_q [OpMaxLen];
  logic [OpLenW-1:0]  op_len_q;
  logic [ByteW-1:0]   seq_byte, hdr_byte;
  logic               done, seq_final, seq_v, seq_emit, seq_free, load, out_adv;
  logic               m_valid_q;
  logic [ByteW-1:0]   m_byte_q;
  logic               m_last_q, m_fend_q;

  assign cur   = pend_q & (~pend_q + 4'd1);
  assign phase = phase_e'(cur);
  assign rest  = pend_q & ~cur;

  always_comb begin
    case (idx_q)
      4'd0:    hdr_byte = Magic0;
      4'd1:    hdr_byte = Magic1;
      4'd2:    hdr_byte = Magic2;
      4'd3:    hdr_byte = Magic3;
      4'd4:    hdr_byte = width_q[31:24];
      4'd5:    hdr_byte = width_q[23:16];
      4'd6:    hdr_byte = width_q[15:8];
      4'd7:    hdr_byte = width_q[7:0];
      4'd8:    hdr_byte = height_q[31:24];
      4'd9:    hdr_byte = height_q[23:16];
      4'd10:   hdr_byte = height_q[15:8];
      4'd11:   hdr_byte = height_q[7:0];
      4'd12:   hdr_byte = {{(ByteW-ChanW){1'b0}}, chan_q};
      default: hdr_byte = '0;
    endcase
  end

  always_comb begin
    case (phase)
      PH_HDR: begin
        seq_byte = hdr_byte;
        done     = (idx_q == SeqIdxW'(HdrLen - 1));
      end
      PH_RUN: begin
        seq_byte = run_byte_q;
        done     = 1'b1;
      end
      PH_OP: begin
        seq_byte = op_q[idx_q[OpLenW-1:0]];
        done     = (idx_q[OpLenW-1:0] == op_len_q - 3'd1);
      end
      PH_END: begin
        done     = (idx_q == SeqIdxW'(EndLen - 1));
        seq_byte = done ? EndFinal : '0;
      end
      default: begin
        seq_byte = '0;
        done     = 1'b0;
      end
    endcase
  end

  assign seq_v     = |pend_q;
  assign seq_final = done && (rest == '0);
  assign out_adv   = !m_valid_q || m_axis_tready_i;
  assign seq_emit  = seq_v && out_adv;
  assign seq_free  = !seq_v || (seq_emit && seq_final);
  assign s1_fire   = s1_v_q && (silent || seq_free);
  assign load      = s1_fire && !silent;
  assign ram_we    = s1_fire && wr;

  always_comb begin
    pend_d = pend_q;
    idx_d  = idx_q;
    if (load) begin
      pend_d = {s1_last_q, op_len_d != '0, run_flush, !hdr_sent_q};
      idx_d  = '0;
    end else if (seq_emit) begin
      if (done) begin
        pend_d = rest;
        idx_d  = '0;
      end else begin
        idx_d  = idx_q + 4'd1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      fwd_hit_q  <= 1'b0;
      vld_q      <= '0;
      prev_q     <= PrevReset;
      run_q      <= '0;
      hdr_sent_q <= 1'b0;
      pend_q     <= '0;
      idx_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      idx_q  <= idx_d;
      if (s_acc) begin
        s1_v_q <= 1'b1;
        // the write of the departing pixel is not yet visible in the RAM read
        fwd_hit_q <= ram_we && !s1_last_q && (s1_hash_q == in_hash);
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (s1_fire) begin
        if (s1_last_q) begin
          vld_q      <= '0;
          prev_q     <= PrevReset;
          run_q      <= '0;
          hdr_sent_q <= 1'b0;
        end else begin
          hdr_sent_q <= 1'b1;
          if (same) begin
            run_q <= flush_same ? '0 : run_inc[RunW-1:0];
          end else begin
            run_q  <= '0;
            prev_q <= s1_px_q;
          end
          if (wr) begin
            vld_q[s1_hash_q] <= 1'b1;
          end
        end
      end
      if (out_adv) begin
        m_valid_q <= seq_v;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_px_q    <= s_axis_tdata_i;
      s1_last_q  <= s_axis_tlast_i;
      s1_hash_q  <= in_hash;
      fwd_data_q <= s1_px_q;
    end
    if (load) begin
      run_byte_q <= run_byte;
      op_len_q   <= op_len_d;
      for (int i = 0; i < OpMaxLen; i++) begin
        op_q[i] <= op_d[i];
      end
    end
    if (seq_emit) begin
      m_byte_q <= seq_byte;
      m_last_q <= seq_final;
      m_fend_q <= (phase == PH_END) && done;
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_byte_q;
  assign m_axis_tlast_o    = m_last_q;
  assign m_axis_tuser_o[0] = m_fend_q;

  // checks
  `QOI_ASSERT_SAME(a_fend_is_last, m_valid_q && m_fend_q, m_last_q)
  `QOI_ASSERT_SAME(a_op_idx_range, phase == PH_OP, !idx_q[3] && (idx_q[2:0] < op_len_q))
  `QOI_ASSERT_SAME(a_run_bound, 1'b1, 7'(run_q) < 7'(MaxRun))
  `QOI_ASSERT_NEXT(a_frame_clear, s1_fire && s1_last_q, !hdr_sent_q && vld_q == '0 && run_q == '0)

endmodule

// File: dv/tb.sv
// Self-checking testbench for the QOI stream encoder: predicts every stream byte per pixel.
module tb
  import qoienc_pkg::*;
();

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             item_end;
    logic             frame_end;
  } stream_byte_t;

  class qoi_stream_scoreboard;
    logic [PixelW-1:0] img_w = 1;
    logic [PixelW-1:0] img_h = 1;
    logic [ChanW-1:0]  chans = 4;
    logic [PixelW-1:0] color_tbl[IndexDepth];
    logic [PixelW-1:0] prev_px;
    int unsigned       run_len;
    bit                hdr_done;
    stream_byte_t      expected_q[$];
    stream_byte_t      pixel_bytes[$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      start_frame();
    endfunction

    function void start_frame();
      foreach (color_tbl[i]) color_tbl[i] = '0;
      prev_px  = PrevReset;
      run_len  = 0;
      hdr_done = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [PixelW-1:0] v);
      case (idx)
        REG_WIDTH:    img_w = v;
        REG_HEIGHT:   img_h = v;
        REG_CHANNELS: chans = v[ChanW-1:0];
        default: ;
      endcase
    endfunction

    function void put(logic [ByteW-1:0] b, bit fe = 1'b0);
      pixel_bytes.push_back(stream_byte_t'{b, 1'b0, fe});
    endfunction

    function void put_be32(logic [PixelW-1:0] v);
      put(v[31:24]);
      put(v[23:16]);
      put(v[15:8]);
      put(v[7:0]);
    endfunction

    // Encode one accepted pixel and queue the bytes it causes.
    function void note_pixel(logic [PixelW-1:0] px, bit last_px);
      logic [IndexAw-1:0] h;
      logic signed [7:0]  dr, dg, db, drg, dbg;
      pixel_bytes.delete();
      if (!hdr_done) begin
        put(Magic0);
        put(Magic1);
        put(Magic2);
        put(Magic3);
        put_be32(img_w);
        put_be32(img_h);
        put({5'd0, chans});
        put(8'h00);
        hdr_done = 1'b1;
      end
      if (px == prev_px) begin
        run_len++;
        if (run_len >= MaxRun || last_px) begin
          put(OpRun | 8'(run_len - 1));
          run_len = 0;
        end
      end else begin
        h = 6'(px[7:0] * 3 + px[15:8] * 5 + px[23:16] * 7 + px[31:24] * 11);
        if (run_len != 0) begin
          put(OpRun | 8'(run_len - 1));
          run_len = 0;
        end
        if (color_tbl[h] == px) begin
          put({2'b00, h});
        end else begin
          color_tbl[h] = px;
          if (px[31:24] == prev_px[31:24]) begin
            dr  = px[7:0] - prev_px[7:0];
            dg  = px[15:8] - prev_px[15:8];
            db  = px[23:16] - prev_px[23:16];
            drg = dr - dg;
            dbg = db - dg;
            if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
              put(OpDiff | {2'b00, 2'(dr + 2), 2'(dg + 2), 2'(db + 2)});
            end else if (drg >= -8 && drg <= 7 && dg >= -32 && dg <= 31 &&
                         dbg >= -8 && dbg <= 7) begin
              put(OpLuma | {2'b00, 6'(dg + 32)});
              put({4'(drg + 8), 4'(dbg + 8)});
            end else begin
              put(OpRgb);
              put(px[7:0]);
              put(px[15:8]);
              put(px[23:16]);
            end
          end else begin
            put(OpRgba);
            put(px[7:0]);
            put(px[15:8]);
            put(px[23:16]);
            put(px[31:24]);
          end
        end
        prev_px = px;
      end
      if (last_px) begin
        repeat (EndLen - 1) put(8'h00);
        put(EndFinal, 1'b1);
        start_frame();
      end
      if (pixel_bytes.size() > 0) pixel_bytes[pixel_bytes.size() - 1].item_end = 1'b1;
      foreach (pixel_bytes[i]) expected_q.push_back(pixel_bytes[i]);
    endfunction

    function void check_byte(logic [ByteW-1:0] d, logic l, logic u);
      stream_byte_t e;
      checked++;
      if (expected_q.size() == 0) begin
        $error("out_byte %h arrived with nothing expected", d);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (e.data !== d) begin
        $error("out_byte expected %h actual %h", e.data, d);
        mismatches++;
      end
      if (e.item_end !== l) begin
        $error("last_of_item expected %b actual %b", e.item_end, l);
        mismatches++;
      end
      if (e.frame_end !== u) begin
        $error("frame_end expected %b actual %b", e.frame_end, u);
        mismatches++;
      end
    endfunction
  endclass

  localparam int unsigned Limit = 1_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_valid = 1'b0;
  logic [PixelW-1:0]  s_data = '0;
  logic               s_last = 1'b0;
  logic               m_ready = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = REG_WIDTH;
  logic [PixelW-1:0]  cfg_data = '0;

  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic [ByteW-1:0]   m_axis_tdata_o;
  logic               m_axis_tlast_o;
  logic [0:0]         m_axis_tuser_o;

  qoi_stream_scoreboard sb = new();

  int unsigned       src_idle = 13;
  int unsigned       snk_idle = 71;
  int unsigned       cycles = 0;
  int unsigned       n_pixels = 0;
  int unsigned       n_frames = 0;
  logic [PixelW-1:0] recent_px[$];

  qoi_image_encoder_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("FAIL qoi_image_encoder_top");
      $finish;
    end
  end

  // Output side: check accepted bytes, then pick next tready.
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_axis_tvalid_o && m_ready)
        sb.check_byte(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o[0]);
      m_ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic send_pixel(logic [PixelW-1:0] px, bit last_px);
    while ($urandom_range(99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= px;
    s_last  <= last_px;
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    sb.note_pixel(px, last_px);
    n_pixels++;
    if (last_px) n_frames++;
    recent_px.push_back(px);
    if (recent_px.size() > 16) void'(recent_px.pop_front());
  endtask

  // Hold the sender until every byte is out; extra cycles cover a silent pixel.
  task automatic drain();
    s_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [PixelW-1:0] w, logic [PixelW-1:0] h,
                            logic [PixelW-1:0] c);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx  <= REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_idx  <= REG_CHANNELS;
    cfg_data <= c;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_reg(REG_WIDTH, w);
    sb.set_reg(REG_HEIGHT, h);
    sb.set_reg(REG_CHANNELS, c);
  endtask

  function automatic logic [PixelW-1:0] next_pixel(logic [PixelW-1:0] p);
    int unsigned kind;
    logic [7:0]  dg8, dr8, db8;
    kind = $urandom_range(99);
    dg8  = 8'($urandom_range(63)) - 8'd32;
    dr8  = dg8 + 8'($urandom_range(15)) - 8'd8;
    db8  = dg8 + 8'($urandom_range(15)) - 8'd8;
    if (kind < 25) return p;
    if (kind < 42)
      return {p[31:24], p[23:16] + 8'($urandom_range(3)) - 8'd2,
              p[15:8] + 8'($urandom_range(3)) - 8'd2, p[7:0] + 8'($urandom_range(3)) - 8'd2};
    if (kind < 58) return {p[31:24], p[23:16] + db8, p[15:8] + dg8, p[7:0] + dr8};
    if (kind < 72 && recent_px.size() > 0)
      return recent_px[$urandom_range(recent_px.size() - 1)];
    if (kind < 82) return {p[31:24], 24'($urandom)};
    if (kind < 94) return $urandom;
    return {8'($urandom), p[23:0]};
  endfunction

  task automatic send_frame(int unsigned len);
    logic [PixelW-1:0] p;
    logic [PixelW-1:0] px;
    int unsigned       runs_left;
    p = PrevReset;
    runs_left = 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (runs_left > 0) begin
        px = p;
        runs_left--;
      end else if ($urandom_range(99) < 4) begin
        // long run, crosses the maximum run length now and then
        runs_left = $urandom_range(70, 45);
        px = p;
      end else begin
        px = next_pixel(p);
      end
      send_pixel(px, i == len - 1);
      p = px;
    end
  endtask

  task automatic run_phase(int unsigned src, int unsigned snk, int unsigned target,
                           logic [PixelW-1:0] chan_val);
    int unsigned start;
    int unsigned len;
    drain();
    src_idle = src;
    snk_idle = snk;
    write_regs($urandom, $urandom_range(4096, 1), chan_val);
    start = n_pixels;
    while (n_pixels - start < target) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(30, 1) : $urandom_range(90, 31);
      if (len > target - (n_pixels - start)) len = target - (n_pixels - start);
      send_frame(len);
    end
  endtask

  task automatic directed();
    logic [PixelW-1:0] fa[14];
    fa = '{32'hff00_0000, 32'hff00_0000, 32'hff01_0101, 32'hff0a_0c0b, 32'hff80_8080,
           32'h7f80_8080, 32'hff01_0101, 32'h0000_0000, 32'hffff_ffff, 32'hfffe_fefe,
           32'hff7f_7f7f, 32'hff96_9eb7, 32'hff7d_7e8f, 32'h0000_0000};
    // first frame runs on the register values left by reset
    foreach (fa[i]) send_pixel(fa[i], i == 13);
    drain();
    write_regs(32'h0000_0000, 32'hffff_ffff, 3);
    send_pixel(32'h1234_5678, 1'b0);
    send_pixel(32'h1234_5678, 1'b1);
    drain();
    write_regs(32'hffff_ffff, 32'h0000_0000, 7);
    send_pixel(32'hff00_0000, 1'b1);
    drain();
    write_regs(32'ha5a5_a5a5, 32'h5a5a_5a5a, 0);
    send_pixel(32'h0000_0000, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    run_phase(13, 71, 140, 3);
    run_phase(71, 13, 140, 4);
    run_phase(0, 0, 132, $urandom_range(7));
    drain();
    $display("Covered %0d pixels in %0d frames; %0d stream bytes checked, %0d mismatches",
             n_pixels, n_frames, sb.checked, sb.mismatches);
    $display("Idle mixes: sender-heavy, receiver-heavy, none; odd sizes and channel bytes");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS qoi_image_encoder_top");
    end else begin
      $display("FAIL qoi_image_encoder_top");
    end
    $finish;
  end
endmodule
